// ----- design/idsu_pkg.sv -----
// shared constants, types and the single restoring-division step
package idsu_pkg;

    localparam int DW = 32;
    localparam int NSTEP = DW;

    // one pipeline stage of the divider
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] nq;
        logic [DW-1:0] dvs;
        logic          neg_q;
        logic          neg_r;
        logic          ovf;
    } stage_t;

    typedef struct packed {
        logic [DW-1:0] quotient;
        logic [DW-1:0] remainder;
        logic          overflow;
    } result_t;

    // shift in next dividend bit, subtract divisor if it fits
    function automatic stage_t div_step(stage_t s);
        stage_t      o;
        logic [DW:0] sh;
        logic [DW+1:0] diff;
        logic        take;
        o    = s;
        sh   = {s.rem, s.nq[DW-1]};
        diff = {1'b0, sh} - {2'b00, s.dvs};
        take = ~diff[DW+1];
        o.rem = take ? diff[DW-1:0] : sh[DW-1:0];
        o.nq  = {s.nq[DW-2:0], take};
        return o;
    endfunction

endpackage

// ----- design/idsu_if.sv -----
// request and result channel interfaces
interface idsu_req_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [idsu_pkg::DW-1:0]  dividend;
    logic [idsu_pkg::DW-1:0]  divisor;

    modport source (output valid, action, dividend, divisor, input ready);
    modport sink   (input valid, action, dividend, divisor, output ready);
endinterface

interface idsu_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [idsu_pkg::DW-1:0]  quotient;
    logic [idsu_pkg::DW-1:0]  remainder;
    logic                     overflow;

    modport source (output valid, quotient, remainder, overflow, input ready);
    modport sink   (input valid, quotient, remainder, overflow, output ready);
endinterface

// ----- design/int_divide_signed_unsigned_unit.sv -----
// pipelined signed/unsigned integer divider, top level
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+------------
//  req     | in  | action, dividend, divisor        | valid/ready
//  rsp     | out | quotient, remainder, overflow    | valid/ready
//
// one request per cycle sustained while the skid entry is empty; a request passes
// one operand stage, one restoring step per quotient bit, then a sign fix into the result register
// the 32 chained subtract steps set the depth, each step owns a register stage
// rst_n clears every valid bit asynchronously, payload registers are not reset
// a two-entry output (result register plus skid) means ready is registered;
// while the skid entry is full the whole pipeline holds, nothing is dropped
module int_divide_signed_unsigned_unit
(
    input  logic           clk,
    input  logic           rst_n,
    idsu_req_if.sink       req,
    idsu_rsp_if.source     rsp
);

    localparam int DW = idsu_pkg::DW;
    localparam int NS = idsu_pkg::NSTEP;

    // pipeline stages: index 0 holds the operand magnitudes
    idsu_pkg::stage_t stg_reg [0:NS];
    logic             vld_reg [0:NS];

    idsu_pkg::result_t out_reg;
    idsu_pkg::result_t skid_reg;
    idsu_pkg::result_t fix;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic              advance;
    idsu_pkg::stage_t  prep;
    logic              sa;
    logic              sb;
    logic              bz;
    logic              incoming;

    // the pipeline moves as one unless the skid entry is occupied
    assign advance   = ~skid_valid_reg;
    assign req.ready = advance;

    // operand preparation: magnitudes and result sign flags
    always_comb
    begin
        sa = req.action & req.dividend[DW-1];
        sb = req.action & req.divisor[DW-1];
        bz = (req.divisor == '0);
        prep.rem   = '0;
        prep.nq    = sa ? (~req.dividend + {{(DW-1){1'b0}}, 1'b1}) : req.dividend;
        prep.dvs   = sb ? (~req.divisor + {{(DW-1){1'b0}}, 1'b1}) : req.divisor;
        // zero divisor: the core yields all ones and the dividend magnitude,
        // so only the quotient sign must be suppressed
        prep.neg_q = (sa ^ sb) & ~bz;
        prep.neg_r = sa;
        // most negative by minus one: core already gives min and zero
        prep.ovf   = req.action & (req.dividend == {1'b1, {(DW-1){1'b0}}})
                     & (req.divisor == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_reg[0] <= prep;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stg_reg[k] <= idsu_pkg::div_step(stg_reg[k-1]);
            end
        end
    end

    // sign fix of the finished magnitudes
    always_comb
    begin
        fix.quotient  = stg_reg[NS].neg_q ? (~stg_reg[NS].nq + {{(DW-1){1'b0}}, 1'b1})
                                          : stg_reg[NS].nq;
        fix.remainder = stg_reg[NS].neg_r ? (~stg_reg[NS].rem + {{(DW-1){1'b0}}, 1'b1})
                                          : stg_reg[NS].rem;
        fix.overflow  = stg_reg[NS].ovf;
    end

    assign incoming = advance & vld_reg[NS];

    // result register with skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= incoming;
            end
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (incoming)
            begin
                out_reg <= fix;
            end
        end
        else if (incoming)
        begin
            skid_reg <= fix;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.quotient  = out_reg.quotient;
    assign rsp.remainder = out_reg.remainder;
    assign rsp.overflow  = out_reg.overflow;

`ifndef ASSERT_OFF
    // skid entry is only filled behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full without a pending result");

    // an accepted request enters the operand stage
    a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> vld_reg[0])
        else $error("accepted request lost at operand stage");

    // overflow case never negates the quotient
    a_ovf_no_neg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && stg_reg[NS].ovf |-> !stg_reg[NS].neg_q)
        else $error("overflow item carries a quotient negation");

    // zero divisor gives an all-ones quotient
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && (stg_reg[NS].dvs == '0) |-> (fix.quotient == '1))
        else $error("divide by zero quotient is not all ones");

    // a held pipeline keeps its last stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg[NS]))
        else $error("pipeline moved while stalled");
`endif

endmodule
